>>> design/gsef_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsef_pkg
// Shared types and constants for the grid-snap extrema filter.
// ----------------------------------------------------------------------------
package gsef_pkg;

    localparam int DATA_W   = 32;          // sample / snapped width
    localparam int STEP_W   = 31;          // grid step register width
    localparam int NUM_W    = 35;          // 2*x + d, signed
    localparam int MAG_W    = 33;          // |2*x + d|
    localparam int DEN_W    = 32;          // 2*d
    localparam int DIV_BITS = MAG_W;       // one quotient bit per step
    localparam int CNT_W    = 6;

    localparam logic [STEP_W-1:0] STEP_RESET = 31'd65536;

    localparam logic signed [NUM_W-1:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [NUM_W-1:0] SAT_MIN = -35'sd2147483648;

    // result slot select
    localparam logic SEL_A = 1'b0;
    localparam logic SEL_B = 1'b1;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] snapped;
        logic                     curve_end;
    } out_item_t;

    typedef struct packed {
        logic load;      // capture request, form 2*x + d
        logic prep;      // take magnitude, clear remainder
        logic step;      // one restoring division step
        logic fin;       // floor correction and saturation
        logic decide;    // extrema decision, fill result slots
        logic emit;      // load output register
        logic emit_sel;  // SEL_A or SEL_B
    } cmd_t;

    typedef struct packed {
        logic slot_a_valid;
        logic slot_b_valid;
        logic slot_free;
    } status_t;

endpackage

>>> design/grid_snap_extrema_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_snap_extrema_filter
// Snaps Q16.16 samples to the grid step and keeps only local extrema.
// ----------------------------------------------------------------------------
// After a request is accepted come a prep step, 33 divide steps (one
//   quotient bit per cycle), a snap, a decide and the output register load.
// One request is handled at a time; a new request is taken once the previous
//   one has its results in the output register, and output stalls on the
//   result side hold it back.
// Reset: rst_n is asynchronous, active low; grid step returns to 1.0, the
//   curve state is cleared and no results are pending.
module grid_snap_extrema_filter (
    input  logic                        clk,
    input  logic                        rst_n,
    // input requests
    input  logic                        in_valid,
    output logic                        in_ready,
    input  gsef_pkg::in_item_t          in_data,
    // results
    output logic                        out_valid,
    input  logic                        out_ready,
    output gsef_pkg::out_item_t         out_data,
    // grid step register; the user keeps it written only while idle, unchecked in the block
    input  logic                        cfg_we,
    input  logic [gsef_pkg::STEP_W-1:0] cfg_data
);
    import gsef_pkg::*;

    // Controller sequences each request; datapath holds all arithmetic and
    // the curve state. The snap is floor((2x + d) / 2d) * d, done as an
    // unsigned restoring divide of |2x + d| followed by a floor correction:
    // q*d = (num - floor_remainder) / 2, so no multiplier is needed.
    cmd_t    cmd;
    status_t status;

    gsef_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Up to two results per request: the first point, a surviving candidate or
    // a lone closing point (slot A) and, at curve end, the closing point (slot
    // B). The output register lets the next request enter while a result waits.
    gsef_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> design/gsef_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsef_ctrl
// Sequencer: accept, divide, snap, decide, then emit up to two results.
// ----------------------------------------------------------------------------
module gsef_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  gsef_pkg::status_t status,
    output gsef_pkg::cmd_t  cmd
);
    import gsef_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN,
        ST_DECIDE,
        ST_EMIT_A,
        ST_EMIT_B
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               div_last;

    assign in_ready = (state_reg == ST_IDLE);
    assign div_last = (cnt_reg == CNT_W'(DIV_BITS - 1));

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.emit_sel = SEL_A;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + CNT_W'(1);
                if (div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_EMIT_A;
            end
            ST_EMIT_A:
            begin
                if (!status.slot_a_valid)
                    state_next = ST_EMIT_B;
                else if (status.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_A;
                    state_next   = ST_EMIT_B;
                end
            end
            ST_EMIT_B:
            begin
                if (!status.slot_b_valid)
                    state_next = ST_IDLE;
                else if (status.slot_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_sel = SEL_B;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // one request in flight at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while previous one in flight");

    // divider always runs its full length before snapping
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> $past(cmd.step) && $past(div_last))
        else $error("snap stage entered before division finished");

endmodule

>>> design/gsef_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsef_dp
// Datapath: serial floor division, snapping, extrema state, output register.
// ----------------------------------------------------------------------------
module gsef_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  gsef_pkg::in_item_t    in_data,
    input  logic                  cfg_we,
    input  logic [gsef_pkg::STEP_W-1:0] cfg_data,
    input  gsef_pkg::cmd_t        cmd,
    output gsef_pkg::status_t     status,
    output logic                  out_valid,
    input  logic                  out_ready,
    output gsef_pkg::out_item_t   out_data
);
    import gsef_pkg::*;

    logic [STEP_W-1:0]        step_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic                     last_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [DEN_W-1:0]         rem_reg;
    logic signed [DATA_W-1:0] p_reg;

    logic                     have_kept_reg, have_kept_next;
    logic signed [DATA_W-1:0] kept_reg, kept_next;
    logic                     have_pend_reg, have_pend_next;
    logic signed [DATA_W-1:0] pend_reg, pend_next;

    logic                     slot_a_valid_reg, slot_a_valid_next;
    logic signed [DATA_W-1:0] slot_a_val_reg, slot_a_val_next;
    logic                     slot_a_end_reg, slot_a_end_next;
    logic                     slot_b_valid_reg, slot_b_valid_next;

    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    logic [DEN_W-1:0]         den;
    logic signed [NUM_W-1:0]  num_in;
    logic signed [NUM_W-1:0]  num_neg;
    logic [MAG_W-1:0]         trial;
    logic                     q_bit;
    logic [DEN_W-1:0]         rfloor;
    logic signed [NUM_W-1:0]  diff;
    logic signed [NUM_W-1:0]  v;
    logic signed [DATA_W-1:0] p_next;
    logic signed [DATA_W-1:0] lo, hi;
    logic                     between;
    logic                     slot_free;

    assign den     = {step_reg, 1'b0};
    assign num_in  = {{2{in_data.sample[DATA_W-1]}}, in_data.sample, 1'b0}
                   + {{(NUM_W-STEP_W){1'b0}}, step_reg};
    assign num_neg = -num_reg;

    // restoring step: remainder stays below den
    assign trial = {rem_reg, mag_reg[MAG_W-1]};
    assign q_bit = (trial >= {1'b0, den});

    // floor remainder; quotient*2d = num - rfloor
    always_comb
    begin
        if (!num_reg[NUM_W-1])
            rfloor = rem_reg;
        else if (rem_reg != '0)
            rfloor = den - rem_reg;
        else
            rfloor = '0;
    end

    assign diff = num_reg - $signed({{(NUM_W-DEN_W){1'b0}}, rfloor});
    assign v    = diff >>> 1;

    always_comb
    begin
        priority if (step_reg == '0)
            p_next = x_reg;
        else if (v > SAT_MAX)
            p_next = SAT_MAX[DATA_W-1:0];
        else if (v < SAT_MIN)
            p_next = SAT_MIN[DATA_W-1:0];
        else
            p_next = v[DATA_W-1:0];
    end

    // extrema decision
    assign lo      = (kept_reg < p_reg) ? kept_reg : p_reg;
    assign hi      = (kept_reg < p_reg) ? p_reg : kept_reg;
    assign between = (lo <= pend_reg) && (pend_reg <= hi);

    always_comb
    begin
        have_kept_next    = have_kept_reg;
        kept_next         = kept_reg;
        have_pend_next    = have_pend_reg;
        pend_next         = pend_reg;
        slot_a_valid_next = 1'b0;
        slot_a_val_next   = p_reg;
        slot_a_end_next   = last_reg;
        slot_b_valid_next = 1'b0;
        if (!have_kept_reg)
        begin
            slot_a_valid_next = 1'b1;
            have_kept_next    = 1'b1;
            kept_next         = p_reg;
        end
        else if (!have_pend_reg)
        begin
            slot_a_valid_next = last_reg;
            if (!last_reg)
            begin
                have_pend_next = 1'b1;
                pend_next      = p_reg;
            end
        end
        else
        begin
            slot_a_valid_next = !between;
            slot_a_val_next   = pend_reg;
            slot_a_end_next   = 1'b0;
            if (!between)
                kept_next = pend_reg;
            slot_b_valid_next = last_reg;
            if (!last_reg)
                pend_next = p_reg;
        end
        // curve closes: back to reset values
        if (last_reg)
        begin
            have_kept_next = 1'b0;
            kept_next      = '0;
            have_pend_next = 1'b0;
            pend_next      = '0;
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_RESET;
            have_kept_reg    <= 1'b0;
            kept_reg         <= '0;
            have_pend_reg    <= 1'b0;
            pend_reg         <= '0;
            slot_a_valid_reg <= 1'b0;
            slot_b_valid_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_data;
            if (cmd.decide)
            begin
                have_kept_reg    <= have_kept_next;
                kept_reg         <= kept_next;
                have_pend_reg    <= have_pend_next;
                pend_reg         <= pend_next;
                slot_a_valid_reg <= slot_a_valid_next;
                slot_b_valid_reg <= slot_b_valid_next;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg    <= in_data.sample;
            last_reg <= in_data.is_last;
            num_reg  <= num_in;
        end
        if (cmd.prep)
        begin
            mag_reg <= num_reg[NUM_W-1] ? num_neg[MAG_W-1:0] : num_reg[MAG_W-1:0];
            rem_reg <= '0;
        end
        if (cmd.step)
        begin
            mag_reg <= {mag_reg[MAG_W-2:0], q_bit};
            rem_reg <= q_bit ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        end
        if (cmd.fin)
            p_reg <= p_next;
        if (cmd.decide)
        begin
            slot_a_val_reg <= slot_a_val_next;
            slot_a_end_reg <= slot_a_end_next;
        end
        if (cmd.emit)
        begin
            if (cmd.emit_sel == SEL_B)
            begin
                out_data_reg.snapped   <= p_reg;
                out_data_reg.curve_end <= 1'b1;
            end
            else
            begin
                out_data_reg.snapped   <= slot_a_val_reg;
                out_data_reg.curve_end <= slot_a_end_reg;
            end
        end
    end

    assign status.slot_a_valid = slot_a_valid_reg;
    assign status.slot_b_valid = slot_b_valid_reg;
    assign status.slot_free    = slot_free;
    assign out_valid           = out_valid_reg;
    assign out_data            = out_data_reg;

    a_pend_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
        have_pend_reg |-> have_kept_reg)
        else $error("candidate held with no kept point");

    // closing point is only ever queued as the curve closes
    a_slot_b_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        slot_b_valid_reg |-> !have_kept_reg && !have_pend_reg)
        else $error("closing point queued outside curve end");

endmodule
